/* src/bbr_pkg.sv */
package bbr_pkg;

	localparam int unsigned PIX_W             = 8;
	localparam int unsigned RADIUS_W          = 5;
	localparam int unsigned MAX_RADIUS_DEF    = 31;
	localparam int unsigned MAX_ROW_WIDTH_DEF = 4096;
	localparam int unsigned RECIP_W           = 32;
	localparam int unsigned RECIP_SHIFT       = 31;

	localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(1);

	// Per-request side information that travels with the window address pair.
	typedef struct packed {
		logic row_last;
		logic run_last;
		logic lo_zero;
	} bbr_flags_t;

endpackage

/* src/bbr_avg_pipe.sv */
module bbr_avg_pipe #(
	parameter int unsigned MAX_RADIUS = bbr_pkg::MAX_RADIUS_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        wr_en,
	input  logic [$clog2(2*MAX_RADIUS+3)-1:0]           wr_addr,
	input  logic [$clog2((2*MAX_RADIUS+1)*255+1)-1:0]   wr_data,
	input  logic                                        in_valid,
	output logic                                        in_ready,
	input  logic [$clog2(2*MAX_RADIUS+3)-1:0]           rd_hi_addr,
	input  logic [$clog2(2*MAX_RADIUS+3)-1:0]           rd_lo_addr,
	input  logic [$clog2(MAX_RADIUS+1)-1:0]             lcnt,
	input  logic [$clog2(MAX_RADIUS+1)-1:0]             rcnt,
	input  logic [bbr_pkg::PIX_W-1:0]                   first_pix,
	input  logic [bbr_pkg::PIX_W-1:0]                   newest_pix,
	input  logic [$clog2(MAX_RADIUS+1)-1:0]             radius,
	input  bbr_pkg::bbr_flags_t                         flags,
	output logic                                        m_tvalid,
	input  logic                                        m_tready,
	output logic [7:0]                                  m_tdata,  // [7:0] blurred
	output logic                                        m_tlast,  // row_last
	output logic                                        m_tuser   // run_last
);

	localparam int unsigned RW     = $clog2(MAX_RADIUS+1);
	localparam int unsigned SUM_W  = $clog2((2*MAX_RADIUS+1)*255+1);
	localparam int unsigned AW     = $clog2(2*MAX_RADIUS+3);
	localparam int unsigned DEPTH  = 2**AW;
	localparam int unsigned PROD_W = SUM_W + bbr_pkg::RECIP_W;

	// Prefix sums of the current row: entry q mod DEPTH holds pixels 0..q, summed modulo 2^SUM_W.
	logic [SUM_W-1:0] mem [DEPTH];

	logic                      valid_s1, valid_s2, valid_s3;
	logic                      rdy1, rdy2, rdy3, ld1;
	logic [SUM_W-1:0]          hi_s1, lo_s1;
	logic [RW-1:0]             lcnt_s1, rcnt_s1, r_s1, r_s2;
	logic [bbr_pkg::PIX_W-1:0] first_s1, newest_s1;
	bbr_pkg::bbr_flags_t       flags_s1, flags_s2, flags_s3;
	logic [SUM_W-1:0]          sum_c, sum_s2;
	logic [bbr_pkg::RECIP_W-1:0] recip_tab [2**RW];
	logic [PROD_W-1:0]         prod_c;
	logic [7:0]                blurred_s3;

	// Reciprocal of each window span, rounded up, as a constant table.
	for (genvar i = 0; i < 2**RW; i++) begin : g_recip
		localparam logic [63:0] RECIP_V =
			((64'd1 << bbr_pkg::RECIP_SHIFT) + 64'(2*i)) / 64'(2*i+1);
		assign recip_tab[i] = RECIP_V[bbr_pkg::RECIP_W-1:0];
	end

	assign rdy3     = !valid_s3 || m_tready;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign in_ready = rdy1;
	assign ld1      = in_valid && rdy1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ld1) begin
			hi_s1 <= mem[rd_hi_addr];
			lo_s1 <= mem[rd_lo_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			lcnt_s1   <= lcnt;
			rcnt_s1   <= rcnt;
			first_s1  <= first_pix;
			newest_s1 <= newest_pix;
			r_s1      <= radius;
			flags_s1  <= flags;
		end
		if (rdy2 && valid_s1) begin
			sum_s2   <= sum_c;
			r_s2     <= r_s1;
			flags_s2 <= flags_s1;
		end
		if (rdy3 && valid_s2) begin
			blurred_s3 <= prod_c[bbr_pkg::RECIP_SHIFT +: 8];
			flags_s3   <= flags_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy1) begin
				valid_s1 <= in_valid;
			end
			if (rdy2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// Clamped copies of the edge pixels plus the span of stored pixels in the window.
	always_comb begin
		sum_c = SUM_W'(lcnt_s1) * SUM_W'(first_s1)
			+ SUM_W'(rcnt_s1) * SUM_W'(newest_s1)
			+ hi_s1
			- (flags_s1.lo_zero ? '0 : lo_s1);
	end

	assign prod_c = sum_s2 * recip_tab[r_s2];

	assign m_tvalid = valid_s3;
	assign m_tdata  = blurred_s3;
	assign m_tlast  = flags_s3.row_last;
	assign m_tuser  = flags_s3.run_last;

	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> 32'(sum_s2) <= (32'(r_s2) * 32'd2 + 32'd1) * 32'd255)
		else $error("window sum exceeds the span times full scale");

	a_row_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && flags_s3.row_last |-> flags_s3.run_last)
		else $error("row end output is not the last output of its request");

endmodule

/* src/box_blur_row_pass_unit.sv */
// Channel   Dir  Handshake             Payload
// s_*       in   s_tvalid / s_tready   tdata[7:0] pixel, tlast row_end
// m_*       out  m_tvalid / m_tready   tdata[7:0] blurred, tlast row_last, tuser run_last
// cfg_*     in   cfg_valid / cfg_ready cfg_data[4:0] radius
//
// One pixel request is taken per cycle while each gives at most one output and issue does
// not stall; a request that drains a row end or follows a radius decrease holds s_tready
// low through its extra outputs (up to MAX_RADIUS), as the prefix-sum memory issues one per cycle unless stalled.
// Each issued output passes through the three result stages; m_tready low stalls the three result
// stages, and issue stalls once they are all full.
// Reset clears the row position, counters and valid bits; radius resets to 1.
module box_blur_row_pass_unit #(
	parameter int unsigned MAX_RADIUS    = bbr_pkg::MAX_RADIUS_DEF,
	parameter int unsigned MAX_ROW_WIDTH = bbr_pkg::MAX_ROW_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] pixel
	input  logic                          s_tlast,   // row_end
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,   // [7:0] blurred
	output logic                          m_tlast,   // row_last
	output logic                          m_tuser,   // run_last
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bbr_pkg::RADIUS_W-1:0]  cfg_data   // radius
);

	localparam int unsigned RW    = $clog2(MAX_RADIUS+1);
	localparam int unsigned PW    = $clog2(MAX_ROW_WIDTH);
	localparam int unsigned EW    = $clog2(MAX_ROW_WIDTH+1);
	localparam int unsigned CW    = ((EW > RW) ? EW : RW) + 2;
	localparam int unsigned NW    = $clog2(MAX_RADIUS+2);
	localparam int unsigned SUM_W = $clog2((2*MAX_RADIUS+1)*255+1);
	localparam int unsigned AW    = $clog2(2*MAX_RADIUS+3);

	logic [bbr_pkg::RADIUS_W-1:0] radius_q;
	logic                         busy_q, last_q;
	logic [PW-1:0]                p_q, nrp_q;
	logic [EW-1:0]                e_q;
	logic [NW-1:0]                n_q;
	logic [RW-1:0]                r_q, r_sat;
	logic [bbr_pkg::PIX_W-1:0]    first_q, newest_q, pix;
	logic [SUM_W-1:0]             prefix_q, prefix_new;

	logic          accept, last_in, c_now, c_next, issue, finishing, pipe_ready;
	logic [CW-1:0] e_c, p_c, r_c, n_c, cap_c, hi_raw, hi_c, lo_m1, pos_c;
	logic [RW-1:0] lcnt, rcnt;
	bbr_pkg::bbr_flags_t flags;

	assign cfg_ready = !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= bbr_pkg::RADIUS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			radius_q <= cfg_data;
		end
	end

	assign r_sat = (8'(radius_q) > 8'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(radius_q);

	assign pix     = s_tdata[bbr_pkg::PIX_W-1:0];
	assign accept  = s_tvalid && s_tready;
	assign last_in = s_tlast || (nrp_q == PW'(MAX_ROW_WIDTH-1));
	assign pos_c   = CW'(nrp_q);
	assign prefix_new = ((nrp_q == '0) ? '0 : prefix_q) + SUM_W'(pix);

	assign e_c   = CW'(e_q);
	assign p_c   = CW'(p_q);
	assign r_c   = CW'(r_q);
	assign n_c   = CW'(n_q);
	assign cap_c = CW'(MAX_RADIUS+1);

	// Outputs wait until the right end of their window has arrived, except at row end.
	assign c_now  = (e_c <= p_c) && (last_q || (e_c + r_c <= p_c)) && (n_c < cap_c);
	assign c_next = (e_c + CW'(1) <= p_c) && (last_q || (e_c + CW'(1) + r_c <= p_c))
		&& (n_c + CW'(1) < cap_c);

	assign issue     = busy_q && c_now && pipe_ready;
	assign finishing = busy_q && (!c_now || (issue && !c_next));
	assign s_tready  = !busy_q || finishing;

	always_comb begin
		hi_raw = e_c + r_c;
		hi_c   = (hi_raw > p_c) ? p_c : hi_raw;
		rcnt   = (hi_raw > p_c) ? RW'(hi_raw - p_c) : '0;
		lcnt   = (e_c < r_c) ? RW'(r_c - e_c) : '0;
		lo_m1  = e_c - r_c - CW'(1);
		flags.lo_zero  = (e_c <= r_c);
		flags.row_last = last_q && (e_c == p_c);
		flags.run_last = !c_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			last_q <= 1'b0;
			p_q    <= '0;
			nrp_q  <= '0;
			e_q    <= '0;
			n_q    <= '0;
			r_q    <= '0;
		end else begin
			if (finishing && last_q) begin
				e_q <= '0;
			end else if (issue) begin
				e_q <= EW'(e_q + 1'b1);
			end
			if (accept) begin
				busy_q <= 1'b1;
				last_q <= last_in;
				p_q    <= nrp_q;
				nrp_q  <= last_in ? '0 : PW'(nrp_q + 1'b1);
				n_q    <= '0;
				r_q    <= r_sat;
			end else begin
				if (finishing) begin
					busy_q <= 1'b0;
				end
				if (issue) begin
					n_q <= NW'(n_q + 1'b1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prefix_q <= prefix_new;
			newest_q <= pix;
			if (nrp_q == '0) begin
				first_q <= pix;
			end
		end
	end

	bbr_avg_pipe #(
		.MAX_RADIUS (MAX_RADIUS)
	) u_pipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (accept),
		.wr_addr    (pos_c[AW-1:0]),
		.wr_data    (prefix_new),
		.in_valid   (busy_q && c_now),
		.in_ready   (pipe_ready),
		.rd_hi_addr (hi_c[AW-1:0]),
		.rd_lo_addr (lo_m1[AW-1:0]),
		.lcnt       (lcnt),
		.rcnt       (rcnt),
		.first_pix  (first_q),
		.newest_pix (newest_q),
		.radius     (r_q),
		.flags      (flags),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

	// The memory depth relies on no more than MAX_RADIUS+1 outputs ever pending.
	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (e_c + cap_c > p_c))
		else $error("pending outputs exceed the window memory reach");

	a_row_drained: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && last_q && !c_now |-> (e_c == p_c + CW'(1)))
		else $error("row ended with outputs still pending");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (n_c <= cap_c))
		else $error("too many outputs issued for one request");

endmodule

/* tb/sv/bbr_row_checker.sv */
module bbr_row_checker #(
	parameter int unsigned MAX_RADIUS    = bbr_pkg::MAX_RADIUS_DEF,
	parameter int unsigned MAX_ROW_WIDTH = bbr_pkg::MAX_ROW_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] pixel
	input  logic                          s_tlast,   // row_end
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [7:0]                    m_tdata,   // [7:0] blurred
	input  logic                          m_tlast,   // row_last
	input  logic                          m_tuser,   // run_last
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [bbr_pkg::RADIUS_W-1:0]  cfg_data,  // radius
	output int                            mismatch_count,
	output int                            blur_pending,
	output int                            blur_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned WIN_DEPTH = 2 * MAX_RADIUS + 1;

	typedef struct packed {
		logic [7:0] blurred;
		logic       row_last;
		logic       run_last;
	} blur_out_t;

	blur_out_t                    blur_queue[$];
	blur_out_t                    oldest;
	logic [7:0]                   win_pixels [WIN_DEPTH];
	logic [12:0]                  row_pos;
	logic [12:0]                  emitted;
	logic [7:0]                   first_pix;
	logic [bbr_pkg::RADIUS_W-1:0] radius;
	int                           errs;
	int                           checked;

	// Positions left of the row repeat its first pixel, right of the newest repeat the newest.
	function automatic logic [7:0] clamped_pixel(int q, int newest);
		if (q < 0)
			return first_pix;
		if (q > newest)
			q = newest;
		return win_pixels[q % WIN_DEPTH];
	endfunction

	function automatic logic [7:0] box_average(int x, int r, int newest);
		longint unsigned sum;
		longint unsigned span;
		longint unsigned recip;
		sum   = 0;
		span  = 2 * r + 1;
		recip = ((64'd1 << 31) + span - 1) / span;
		for (int q = x - r; q <= x + r; q++)
			sum += clamped_pixel(q, newest);
		return 8'((sum * recip) >> 31);
	endfunction

	function automatic void predict_outputs(logic [7:0] pix, logic row_end);
		int        p;
		int        r;
		int        x;
		int        n;
		logic      last;
		logic      more;
		blur_out_t item;
		p    = int'(row_pos);
		r    = (radius > MAX_RADIUS) ? int'(MAX_RADIUS) : int'(radius);
		last = row_end;
		x    = int'(emitted);
		n    = 0;
		if (p == 0)
			first_pix = pix;
		win_pixels[p % WIN_DEPTH] = pix;
		if (p >= int'(MAX_ROW_WIDTH) - 1)
			last = 1'b1;
		while (x <= p && (last || x + r <= p) && n < int'(MAX_RADIUS) + 1) begin
			// The final output of this request carries run_last.
			more = (x + 1 <= p) && (last || x + 1 + r <= p) &&
			       (n + 1 < int'(MAX_RADIUS) + 1);
			item.blurred  = box_average(x, r, p);
			item.row_last = last && (x == p);
			item.run_last = !more;
			blur_queue.push_back(item);
			x++;
			n++;
		end
		if (last) begin
			row_pos = '0;
			emitted = '0;
		end else begin
			row_pos = 13'(p + 1);
			emitted = 13'(x);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blur_queue.delete();
			for (int i = 0; i < WIN_DEPTH; i++)
				win_pixels[i] = '0;
			row_pos   = '0;
			emitted   = '0;
			first_pix = '0;
			radius    = bbr_pkg::RADIUS_RESET;
			errs      = 0;
			checked   = 0;
			mismatch_count <= 0;
			blur_pending   <= 0;
			blur_checked   <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				radius = cfg_data;
			if (s_tvalid && s_tready)
				predict_outputs(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				if (blur_queue.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("unexpected output: pix=%0d row_last=%b run_last=%b",
						         m_tdata, m_tlast, m_tuser);
				end else begin
					oldest = blur_queue.pop_front();
					checked++;
					if (m_tdata !== oldest.blurred || m_tlast !== oldest.row_last ||
					    m_tuser !== oldest.run_last) begin
						errs++;
						if (errs <= 10)
							$display("output %0d: expected pix=%0d row_last=%b run_last=%b, got pix=%0d row_last=%b run_last=%b",
							         checked, oldest.blurred, oldest.row_last,
							         oldest.run_last, m_tdata, m_tlast, m_tuser);
					end
				end
			end
			mismatch_count <= errs;
			blur_pending   <= blur_queue.size();
			blur_checked   <= checked;
		end
	end

endmodule

/* tb/sv/tb_box_blur_row_pass_unit.sv */
module tb_box_blur_row_pass_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 400000;

	logic                         clk       = 1'b0;
	logic                         arst_n    = 1'b0;
	logic                         s_tvalid  = 1'b0;
	logic [7:0]                   s_tdata   = '0;
	logic                         s_tlast   = 1'b0;
	logic                         m_tready  = 1'b0;
	logic                         cfg_valid = 1'b0;
	logic [bbr_pkg::RADIUS_W-1:0] cfg_data  = '0;
	logic                         s_tready;
	logic                         m_tvalid;
	logic [7:0]                   m_tdata;
	logic                         m_tlast;
	logic                         m_tuser;
	logic                         cfg_ready;

	int mismatch_count;
	int blur_pending;
	int blur_checked;
	int src_idle_pct = 20;
	int dst_idle_pct = 71;
	int pixels_sent  = 0;
	int cycle_count  = 0;

	box_blur_row_pass_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	bbr_row_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tlast        (s_tlast),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tlast        (m_tlast),
		.m_tuser        (m_tuser),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.blur_pending   (blur_pending),
		.blur_checked   (blur_checked)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= dst_idle_pct);

	task automatic send_pixel(input logic [7:0] pix, input logic row_end);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= pix;
		s_tlast  <= row_end;
		do
			@(posedge clk);
		while (!s_tready);
		pixels_sent++;
	endtask

	task automatic send_row(input int width, input logic close_row);
		logic [7:0] pix;
		for (int i = 0; i < width; i++) begin
			case ($urandom_range(7))
				0:       pix = 8'd0;
				1:       pix = 8'd255;
				default: pix = 8'($urandom_range(255));
			endcase
			send_pixel(pix, close_row && (i == width - 1));
		end
	endtask

	// Holds the source until every predicted output is back, plus the pipeline tail.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (blur_pending != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_radius(input logic [bbr_pkg::RADIUS_W-1:0] r);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= r;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int                           phase_start;
		int                           rows;
		int                           width;
		logic [bbr_pkg::RADIUS_W-1:0] next_radius;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset radius of one: a single-pixel row clamps at both edges.
		send_pixel(8'd0, 1'b1);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd255, 1'b1);

		write_radius(5'd0);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd128, 1'b1);

		// Widest window over a row much narrower than it.
		write_radius(5'd31);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd255, 1'b1);

		// Radius dropped mid row releases every pending position in one request.
		send_row(6, 1'b0);
		write_radius(5'd0);
		send_pixel(8'd77, 1'b0);
		write_radius(5'd31);
		send_row(3, 1'b1);

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				1: begin
					src_idle_pct <= 71;
					dst_idle_pct <= 20;
				end
				2: begin
					src_idle_pct <= 0;
					dst_idle_pct <= 0;
				end
				default: ;
			endcase
			phase_start = pixels_sent;
			while (pixels_sent - phase_start < 100) begin
				case ($urandom_range(3))
					0:       next_radius = 5'd0;
					1:       next_radius = 5'd31;
					default: next_radius = 5'($urandom_range(1, 30));
				endcase
				write_radius(next_radius);
				rows = $urandom_range(2, 4);
				for (int k = 0; k < rows; k++) begin
					if ($urandom_range(4) == 0)
						width = $urandom_range(13, 70);
					else
						width = $urandom_range(1, 12);
					// An open last row lets the next radius take effect mid row.
					send_row(width, (k < rows - 1) || ($urandom_range(2) != 0));
				end
				if ($urandom_range(7) == 0)
					wait_drained();
			end
		end

		// Close whatever row is still open so its tail is drained.
		send_row(3, 1'b1);

		wait_drained();
		repeat (20) @(posedge clk);

		$display("Sent %0d pixel requests and checked %0d blurred outputs.",
		         pixels_sent, blur_checked);
		$display("Radius ran from 0 to 31 with mid-row changes, short rows and wide rows.");
		if (mismatch_count == 0 && blur_pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
